FILE: rtl/core/olads_pkg.sv
// Package for the ordered list core: sizes, request and status codes,
// and the control word that the sequencer hands to every list cell.
// No dependencies.
`default_nettype none

package olads_pkg;

  // Number of list cells, the index and count widths sized for it, and the entry width.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned DATA_W   = 32;

  // Request codes carried on the mode field.
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SORT   = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  // Status codes carried on every result.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Operation that every cell performs in a given cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_LOAD,
    CELL_SWAP,
    CELL_ROTATE
  } cell_op_e;

  // Control word broadcast along the row of cells.
  typedef struct packed {
    cell_op_e                   op;
    logic                       parity;
    logic                       sort;
    logic signed [DATA_W-1:0]   operand;
    logic        [CNT_W-1:0]    count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/olads_cell.sv
// One list cell: holds an entry, its ordering flag and its tally bit, and
// trades them with its neighbours under the broadcast control word.
// Depends on olads_pkg.
`default_nettype none

module olads_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire olads_pkg::cell_ctrl_t       ctrl_i,
  input  wire  [olads_pkg::IDX_W-1:0]      idx_i,
  // Left neighbour.
  input  wire  signed [olads_pkg::DATA_W-1:0] left_value_i,
  input  wire                              left_hi_i,
  input  wire                              left_swap_i,
  // Right neighbour.
  input  wire  signed [olads_pkg::DATA_W-1:0] right_value_i,
  input  wire                              right_hi_i,
  input  wire                              right_tally_i,
  // This cell.
  output logic signed [olads_pkg::DATA_W-1:0] value_o,
  output logic                             hi_o,
  output logic                             tally_o,
  output logic                             swap_right_o
);

  import olads_pkg::*;

  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     hi_q, hi_d;
  logic                     tally_q, tally_d;
  logic                     is_first, is_last;
  logic                     pair_right, pair_left;
  logic                     in_list, match;

  assign is_first = (idx_i == '0);
  assign is_last  = (idx_i == IDX_W'(CAPACITY - 1));

  // In each phase a cell pairs either with its right or with its left neighbour.
  assign pair_right = (idx_i[0] == ctrl_i.parity) && !is_last;
  assign pair_left  = (idx_i[0] != ctrl_i.parity) && !is_first;

  // The pair swaps when the left entry orders after the right one. A flagged
  // entry orders after any unflagged one; on a sort two unflagged entries
  // compare by signed value.
  assign swap_right_o = pair_right &&
                        ((hi_q && !right_hi_i) ||
                         (ctrl_i.sort && !hi_q && !right_hi_i && (value_q > right_value_i)));

  assign in_list = (CNT_W'(idx_i) < ctrl_i.count);
  assign match   = !ctrl_i.sort && (value_q == ctrl_i.operand);

  // Next state of the cell.
  always_comb begin
    value_d = value_q;
    hi_d    = hi_q;
    tally_d = tally_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_APPEND: begin
        if (CNT_W'(idx_i) == ctrl_i.count) begin
          value_d = ctrl_i.operand;
        end
      end
      CELL_LOAD: begin
        hi_d    = !in_list || match;
        tally_d = in_list && match;
      end
      CELL_SWAP: begin
        if (swap_right_o) begin
          value_d = right_value_i;
          hi_d    = right_hi_i;
        end else if (pair_left && left_swap_i) begin
          value_d = left_value_i;
          hi_d    = left_hi_i;
        end
        tally_d = is_last ? 1'b0 : right_tally_i;
      end
      CELL_ROTATE: begin
        value_d = right_value_i;
      end
      default: begin
      end
    endcase
  end

  // Flags are control state and are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q    <= 1'b0;
      tally_q <= 1'b0;
    end else begin
      hi_q    <= hi_d;
      tally_q <= tally_d;
    end
  end

  // The entry itself is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign hi_o    = hi_q;
  assign tally_o = tally_q;

endmodule

`default_nettype wire

FILE: rtl/core/ordered_list_append_delete_sort_core.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of
// cells. An append, a sort of under two entries and a delete or read-out
// on an empty list are answered in the cycle after acceptance. Other
// deletes and sorts run a set-up step that flags the entries, CAPACITY
// odd-even transposition phases over the cell row (which also shift out
// the removed tally) and an answering step. Read-out emits one entry per
// cycle while the output is taken and then rotates the row back into place,
// so the row is busy for CAPACITY rotations in all. A new request is taken
// only when the list is idle and the output register is free or draining.
// Depends on olads_pkg and olads_cell.
`default_nettype none

module ordered_list_append_delete_sort_core (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Request channel.
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [1:0]                           mode_i,
  input  wire  signed [olads_pkg::DATA_W-1:0]  operand_value_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [olads_pkg::DATA_W-1:0]  entry_value_o,
  output logic [olads_pkg::CNT_W-1:0]          removed_count_o,
  output logic [1:0]                           status_o,
  output logic                                 last_o
);

  import olads_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_STEP,
    S_FINISH,
    S_READ,
    S_RESTORE
  } state_e;

  state_e                   state_q;
  logic [1:0]               mode_q;
  logic signed [DATA_W-1:0] operand_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         tally_q;
  logic [CNT_W-1:0]         k_q;
  logic [IDX_W-1:0]         phase_q;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] entry_value_q;
  logic [CNT_W-1:0]         removed_count_q;
  logic [1:0]               status_q;
  logic                     last_q;

  logic                     slot_free;
  logic                     accept;
  logic                     is_full;
  logic                     load_out;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic                     cell_hi    [CAPACITY];
  logic                     cell_tally [CAPACITY];
  logic                     cell_swap  [CAPACITY];

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CNT_W'(CAPACITY));

  // A result enters the output register in this cycle.
  assign load_out = (accept && ((mode_i == MODE_APPEND) ||
                                ((mode_i == MODE_SORT) && (count_q < CNT_W'(2))) ||
                                (count_q == '0))) ||
                    (((state_q == S_FINISH) || (state_q == S_READ)) && slot_free);

  // Control word for the cell row.
  always_comb begin
    ctrl.parity  = phase_q[0];
    ctrl.sort    = (mode_q == MODE_SORT);
    ctrl.operand = (state_q == S_IDLE) ? operand_value_i : operand_q;
    ctrl.count   = count_q;
    ctrl.op      = CELL_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (mode_i == MODE_APPEND) && !is_full) begin
          ctrl.op = CELL_APPEND;
        end
      end
      S_SETUP:   ctrl.op = CELL_LOAD;
      S_STEP:    ctrl.op = CELL_SWAP;
      S_READ:    ctrl.op = slot_free ? CELL_ROTATE : CELL_HOLD;
      S_RESTORE: ctrl.op = CELL_ROTATE;
      S_FINISH:  ctrl.op = CELL_HOLD;
      default:   ctrl.op = CELL_HOLD;
    endcase
  end

  // Row of cells, closed into a ring so that read-out can rotate it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olads_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .idx_i         (IDX_W'(i)),
      .left_value_i  (cell_value[(i + CAPACITY - 1) % CAPACITY]),
      .left_hi_i     (cell_hi[(i + CAPACITY - 1) % CAPACITY]),
      .left_swap_i   (cell_swap[(i + CAPACITY - 1) % CAPACITY]),
      .right_value_i (cell_value[(i + 1) % CAPACITY]),
      .right_hi_i    (cell_hi[(i + 1) % CAPACITY]),
      .right_tally_i (cell_tally[(i + 1) % CAPACITY]),
      .value_o       (cell_value[i]),
      .hi_o          (cell_hi[i]),
      .tally_o       (cell_tally[i]),
      .swap_right_o  (cell_swap[i])
    );
  end

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      mode_q          <= MODE_APPEND;
      operand_q       <= '0;
      count_q         <= '0;
      tally_q         <= '0;
      k_q             <= '0;
      phase_q         <= '0;
      out_valid_q     <= 1'b0;
      entry_value_q   <= '0;
      removed_count_q <= '0;
      status_q        <= STATUS_OK;
      last_q          <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q    <= mode_i;
            operand_q <= operand_value_i;
            tally_q   <= '0;
            phase_q   <= '0;
            k_q       <= '0;
            priority if (mode_i == MODE_APPEND) begin
              entry_value_q   <= '0;
              removed_count_q <= '0;
              last_q          <= 1'b1;
              if (is_full) begin
                status_q <= STATUS_FULL;
              end else begin
                status_q <= STATUS_OK;
                count_q  <= count_q + CNT_W'(1);
              end
            end else if ((mode_i == MODE_SORT) && (count_q < CNT_W'(2))) begin
              // Nothing to reorder.
              entry_value_q   <= '0;
              removed_count_q <= '0;
              status_q        <= STATUS_OK;
              last_q          <= 1'b1;
            end else if (count_q == '0) begin
              // Delete or read-out on an empty list.
              entry_value_q   <= '0;
              removed_count_q <= '0;
              status_q        <= STATUS_EMPTY;
              last_q          <= 1'b1;
            end else if (mode_i == MODE_READ) begin
              state_q <= S_READ;
            end else begin
              state_q <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          state_q <= S_STEP;
        end
        S_STEP: begin
          // Cell 0 holds the next tally bit as the tally row shifts down.
          tally_q <= tally_q + CNT_W'(cell_tally[0]);
          phase_q <= phase_q + IDX_W'(1);
          if (phase_q == IDX_W'(CAPACITY - 1)) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            entry_value_q   <= '0;
            status_q        <= STATUS_OK;
            last_q          <= 1'b1;
            if (mode_q == MODE_DELETE) begin
              removed_count_q <= tally_q;
              count_q         <= count_q - tally_q;
            end else begin
              removed_count_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          if (slot_free) begin
            entry_value_q   <= cell_value[0];
            removed_count_q <= '0;
            status_q        <= STATUS_OK;
            last_q          <= (k_q == count_q - CNT_W'(1));
            k_q             <= k_q + CNT_W'(1);
            if (k_q == count_q - CNT_W'(1)) begin
              state_q <= is_full ? S_IDLE : S_RESTORE;
            end
          end
        end
        S_RESTORE: begin
          // Finish the full turn so that entry 0 is back in cell 0.
          k_q <= k_q + CNT_W'(1);
          if (k_q == CNT_W'(CAPACITY - 1)) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign entry_value_o   = entry_value_q;
  assign removed_count_o = removed_count_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

`ifndef NO_ASSERTIONS
  // The fill count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // An append to a list with room grows it by exactly one.
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_APPEND) && !is_full) |=>
      (count_q == $past(count_q) + CNT_W'(1)))
    else $error("append did not grow the list");

  // Read-out only ever runs on a non-empty list.
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (count_q != '0))
    else $error("read-out on an empty list");

  // A delete never removes more entries than the list holds.
  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |-> (tally_q <= count_q))
    else $error("removed count exceeds the list");
`endif

endmodule

`default_nettype wire
